FILE: rtl/pure_pursuit_lookahead_point_assert.svh
// Assertion macros used by the lookahead point controller.
`ifndef PURE_PURSUIT_LOOKAHEAD_POINT_ASSERT_SVH
`define PURE_PURSUIT_LOOKAHEAD_POINT_ASSERT_SVH
`ifndef SYNTHESIS
`define PPL_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lookahead point assertion failed");
`define PPL_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("lookahead point assertion failed");
`else
`define PPL_ASSERT(lbl, prop)
`define PPL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/ppl_pkg.sv
// Package with widths, codes and control types of the lookahead point block.
`default_nettype none
package ppl_pkg;
   localparam int CW       = 32;          // coordinate width
   localparam int RW       = 25;          // radius width
   localparam int DW       = CW + 1;      // coordinate difference width
   localparam int PW       = 2 * DW;      // product of two differences
   localparam int SW       = PW + 2;      // dot and cross product sums
   localparam int MW       = PW;          // serial multiplier operand width
   localparam int AW       = 2 * MW;      // serial multiplier product width
   localparam int R2W      = 2 * RW;      // squared radius width
   localparam int DQW      = 118;         // discriminant width fed to the root
   localparam int SQ_ITER  = DQW / 2;     // one root bit per step
   localparam int ROOTW    = SQ_ITER;
   localparam int REMW     = ROOTW + 4;
   localparam int T_BITS   = 30;          // fraction bits of the segment parameter
   localparam int QW       = T_BITS + 1;
   localparam int DIV_ITER = QW;
   localparam int DVW      = MW + 1;      // divider remainder width
   localparam int GOAL_LIM = 25;          // goal offsets at or above 2^25 are never within
   localparam int CNTW     = 7;

   localparam logic [RW-1:0] RADIUS_RESET = 25'd98304;
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_POINT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIFF, ST_PROD, ST_MUL, ST_DISC, ST_SQRT,
      ST_NUM, ST_DIV, ST_LERP, ST_FIN, ST_GOAL, ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      MS_NONE, MS_DXDX, MS_DYDY, MS_FXDX, MS_FYDY, MS_DXFY, MS_DYFX,
      MS_RR, MS_GXGX, MS_GYGY, MS_TX, MS_TY
   } mul_sel_type;

   typedef struct packed {
      logic        ready;
      logic        load;
      logic        diff;
      mul_sel_type mul_sel;
      logic        ser_load;
      logic        ser_step;
      logic        disc;
      logic        sqrt_step;
      logic        num;
      logic        div_step;
      logic        div_first;
      logic        fin;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic is_start;
      logic is_last;
      logic have_prev;
      logic zero_len;
      logic disc_neg;
      logic no_root;
      logic out_busy;
   } status_type;
endpackage
`default_nettype wire

FILE: rtl/ppl_if.sv
// Request and response channel interfaces of the lookahead point block.
`default_nettype none
interface ppl_req_if;
   import ppl_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 command;
   logic signed [CW-1:0] car_x;
   logic signed [CW-1:0] car_y;
   logic signed [CW-1:0] goal_x;
   logic signed [CW-1:0] goal_y;
   logic signed [CW-1:0] point_x;
   logic signed [CW-1:0] point_y;
   logic                 last;
   modport source (output valid, command, car_x, car_y, goal_x, goal_y,
                   point_x, point_y, last, input ready);
   modport sink (input valid, command, car_x, car_y, goal_x, goal_y,
                 point_x, point_y, last, output ready);
endinterface

interface ppl_rsp_if;
   import ppl_pkg::*;
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] target_x;
   logic signed [CW-1:0] target_y;
   logic                 found;
   modport source (output valid, target_x, target_y, found, input ready);
   modport sink (input valid, target_x, target_y, found, output ready);
endinterface
`default_nettype wire

FILE: rtl/pure_pursuit_lookahead_point.sv
// Top level of the pure pursuit lookahead point block.
// A start transaction is taken in the idle state alone; a path point without a previous
// point also passes the finish state. A point that closes a segment runs, as far as it
// needs, the serial 66-bit multiplier, the 59-step square root and the 31-step divider,
// one bit per cycle each. A last point adds the goal check and the result register load.
// Reset is synchronous and active high; it clears the query state and the radius to 1.5 m.
`default_nettype none
module pure_pursuit_lookahead_point (
   input  logic                   clock,
   input  logic                   reset,
   ppl_req_if.sink                req,
   ppl_rsp_if.source              rsp,
   input  logic                   csr_wr_en,
   input  logic [ppl_pkg::RW-1:0] csr_wr_data
);
   import ppl_pkg::*;

   // The controller only hands out strobes; all arithmetic, the query state and
   // the result register live in the datapath. The result register frees the
   // request side, so a new transaction is taken while a result still waits.
   cmd_type    cmd;
   status_type status;

   ppl_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // The datapath holds the radius register, written whenever the write enable is high;
   // software must write it only while no query is in flight; the block does not enforce it.
   ppl_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req         (req),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );
endmodule
`default_nettype wire

FILE: rtl/ppl_datapath.sv
// Datapath: query state, shared multiplier, serial multiplier, root and divider.
`default_nettype none
module ppl_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  ppl_pkg::cmd_type      cmd,
   output ppl_pkg::status_type   status,
   ppl_req_if.sink               req,
   ppl_rsp_if.source             rsp,
   input  logic                  csr_wr_en,
   input  logic [ppl_pkg::RW-1:0] csr_wr_data
);
   import ppl_pkg::*;

   localparam logic signed [PW-1:0] RND = PW'(1) << (T_BITS - 1);
   localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

   logic [RW-1:0]        radius_ff, radius_in;
   logic signed [CW-1:0] car_x_ff, car_x_in, car_y_ff, car_y_in;
   logic signed [CW-1:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic signed [CW-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [CW-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [CW-1:0] best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic signed [DW-1:0] gdx_ff, gdx_in, gdy_ff, gdy_in;
   logic signed [DW-1:0] dx_ff, dx_in, dy_ff, dy_in, fx_ff, fx_in, fy_ff, fy_in;
   logic                 last_ff, last_in, have_prev_ff, have_prev_in, hit_ff, hit_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   mul_sel_type          psel_ff, psel_in;
   logic signed [SW-1:0] a_ff, a_in, h_ff, h_in, cr_ff, cr_in, g2_ff, g2_in;
   logic [R2W-1:0]       r2_ff, r2_in;
   logic [MW-1:0]        ma_ff, ma_in, mb_ff, mb_in, b1_ff, b1_in, b2_ff, b2_in;
   logic [AW-1:0]        acc1_ff, acc1_in, acc2_ff, acc2_in;
   logic [DQW-1:0]       dq_ff, dq_in;
   logic [REMW-1:0]      rem_ff, rem_in;
   logic [ROOTW-1:0]     root_ff, root_in;
   logic [DVW-1:0]       drem_ff, drem_in;
   logic [QW-1:0]        q_ff, q_in;
   logic                 out_valid_ff, out_valid_in, out_found_ff, out_found_in;
   logic signed [CW-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;

   logic signed [DW-1:0] op_a, op_b, abs_dx, abs_dy, gdx_abs, gdy_abs;
   logic signed [PW-1:0] rnd_sum;
   logic [DW-1:0]        off;
   logic signed [SW-1:0] prod_ext, cr_abs, root_s, n1, n2, num_sel;
   logic                 in1, in2, goal_near;
   logic [AW-1:0]        diff;
   logic [REMW-1:0]      sq_tmp, sq_trial;
   logic [DVW-1:0]       div_t, a_div;

   function automatic logic signed [CW-1:0] lerp_sat(input logic signed [CW-1:0] p1,
                                                     input logic neg,
                                                     input logic [DW-1:0] offv);
      logic signed [CW+2:0] v;
      logic                 ovf;
      v = neg ? (CW+3)'(p1) - $signed({2'b00, offv}) : (CW+3)'(p1) + $signed({2'b00, offv});
      ovf = !((&v[CW+2:CW-1]) || !(|v[CW+2:CW-1]));
      return ovf ? (v[CW+2] ? SAT_MIN : SAT_MAX) : v[CW-1:0];
   endfunction

   always_comb begin
      abs_dx  = dx_ff[DW-1] ? -dx_ff : dx_ff;
      abs_dy  = dy_ff[DW-1] ? -dy_ff : dy_ff;
      gdx_abs = gdx_ff[DW-1] ? -gdx_ff : gdx_ff;
      gdy_abs = gdy_ff[DW-1] ? -gdy_ff : gdy_ff;
      case (cmd.mul_sel)
         MS_DXDX: begin op_a = dx_ff; op_b = dx_ff; end
         MS_DYDY: begin op_a = dy_ff; op_b = dy_ff; end
         MS_FXDX: begin op_a = fx_ff; op_b = dx_ff; end
         MS_FYDY: begin op_a = fy_ff; op_b = dy_ff; end
         MS_DXFY: begin op_a = dx_ff; op_b = fy_ff; end
         MS_DYFX: begin op_a = dy_ff; op_b = fx_ff; end
         MS_RR: begin
            op_a = $signed({{(DW-RW){1'b0}}, radius_ff});
            op_b = $signed({{(DW-RW){1'b0}}, radius_ff});
         end
         MS_GXGX: begin op_a = gdx_ff; op_b = gdx_ff; end
         MS_GYGY: begin op_a = gdy_ff; op_b = gdy_ff; end
         MS_TX: begin op_a = abs_dx; op_b = $signed({{(DW-QW){1'b0}}, q_ff}); end
         MS_TY: begin op_a = abs_dy; op_b = $signed({{(DW-QW){1'b0}}, q_ff}); end
         default: begin op_a = '0; op_b = '0; end
      endcase
      prod_in  = op_a * op_b;
      prod_ext = SW'(prod_ff);
      rnd_sum  = prod_ff + RND;
      off      = rnd_sum[T_BITS+DW-1:T_BITS];
      cr_abs   = cr_ff[SW-1] ? -cr_ff : cr_ff;
      diff     = acc2_ff - acc1_ff;
      sq_tmp   = {rem_ff[REMW-3:0], dq_ff[DQW-1:DQW-2]};
      sq_trial = REMW'({root_ff, 2'b01});
      root_s   = $signed({{(SW-ROOTW){1'b0}}, root_ff});
      n1       = root_s - h_ff;
      n2       = -h_ff - root_s;
      in1      = !n1[SW-1] && (n1 <= a_ff);
      in2      = !n2[SW-1] && (n2 <= a_ff);
      num_sel  = in1 ? n1 : n2;
      a_div    = a_ff[DVW-1:0];
      div_t    = cmd.div_first ? drem_ff : {drem_ff[DVW-2:0], 1'b0};
      goal_near = (gdx_abs[DW-1:GOAL_LIM] == '0) && (gdy_abs[DW-1:GOAL_LIM] == '0) &&
                  (g2_ff < $signed({{(SW-R2W){1'b0}}, r2_ff}));

      radius_in = csr_wr_en ? csr_wr_data : radius_ff;
      car_x_in = car_x_ff;   car_y_in = car_y_ff;
      goal_x_in = goal_x_ff; goal_y_in = goal_y_ff;
      gdx_in = gdx_ff;       gdy_in = gdy_ff;
      prev_x_in = prev_x_ff; prev_y_in = prev_y_ff;
      cur_x_in = cur_x_ff;   cur_y_in = cur_y_ff;
      best_x_in = best_x_ff; best_y_in = best_y_ff;
      last_in = last_ff;     have_prev_in = have_prev_ff; hit_in = hit_ff;
      dx_in = dx_ff; dy_in = dy_ff; fx_in = fx_ff; fy_in = fy_ff;
      psel_in = cmd.mul_sel;
      a_in = a_ff; h_in = h_ff; cr_in = cr_ff; g2_in = g2_ff; r2_in = r2_ff;
      ma_in = ma_ff; mb_in = mb_ff; b1_in = b1_ff; b2_in = b2_ff;
      acc1_in = acc1_ff; acc2_in = acc2_ff;
      dq_in = dq_ff; rem_in = rem_ff; root_in = root_ff;
      drem_in = drem_ff; q_in = q_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_x_in = out_x_ff; out_y_in = out_y_ff; out_found_in = out_found_ff;

      // Retire the product issued in the previous cycle.
      case (psel_ff)
         MS_DXDX: a_in = prod_ext;
         MS_DYDY: a_in = a_ff + prod_ext;
         MS_FXDX: h_in = prod_ext;
         MS_FYDY: h_in = h_ff + prod_ext;
         MS_DXFY: cr_in = prod_ext;
         MS_DYFX: cr_in = cr_ff - prod_ext;
         MS_RR:   r2_in = prod_ff[R2W-1:0];
         MS_GXGX: g2_in = prod_ext;
         MS_GYGY: g2_in = g2_ff + prod_ext;
         MS_TX:   best_x_in = lerp_sat(prev_x_ff, dx_ff[DW-1], off);
         MS_TY: begin
            best_y_in = lerp_sat(prev_y_ff, dy_ff[DW-1], off);
            hit_in = 1'b1;
         end
         default: ;
      endcase

      if (cmd.load) begin
         if (req.command == CMD_START) begin
            car_x_in = req.car_x;   car_y_in = req.car_y;
            goal_x_in = req.goal_x; goal_y_in = req.goal_y;
            gdx_in = DW'(req.goal_x) - DW'(req.car_x);
            gdy_in = DW'(req.goal_y) - DW'(req.car_y);
            have_prev_in = 1'b0;
            hit_in = 1'b0;
            best_x_in = '0;
            best_y_in = '0;
         end else begin
            cur_x_in = req.point_x;
            cur_y_in = req.point_y;
            last_in = req.last;
         end
      end
      if (cmd.diff) begin
         dx_in = DW'(cur_x_ff) - DW'(prev_x_ff);
         dy_in = DW'(cur_y_ff) - DW'(prev_y_ff);
         fx_in = DW'(prev_x_ff) - DW'(car_x_ff);
         fy_in = DW'(prev_y_ff) - DW'(car_y_ff);
      end
      if (cmd.ser_load) begin
         ma_in = cr_abs[MW-1:0];
         b1_in = cr_abs[MW-1:0];
         mb_in = a_ff[MW-1:0];
         b2_in = MW'(r2_ff);
         acc1_in = '0;
         acc2_in = '0;
      end
      if (cmd.ser_step) begin
         acc1_in = {acc1_ff[AW-2:0], 1'b0} + (b1_ff[MW-1] ? AW'(ma_ff) : '0);
         acc2_in = {acc2_ff[AW-2:0], 1'b0} + (b2_ff[MW-1] ? AW'(mb_ff) : '0);
         b1_in = {b1_ff[MW-2:0], 1'b0};
         b2_in = {b2_ff[MW-2:0], 1'b0};
      end
      if (cmd.disc) begin
         dq_in = diff[DQW-1:0];
         rem_in = '0;
         root_in = '0;
      end
      if (cmd.sqrt_step) begin
         dq_in = {dq_ff[DQW-3:0], 2'b00};
         if (sq_tmp >= sq_trial) begin
            rem_in = sq_tmp - sq_trial;
            root_in = {root_ff[ROOTW-2:0], 1'b1};
         end else begin
            rem_in = sq_tmp;
            root_in = {root_ff[ROOTW-2:0], 1'b0};
         end
      end
      if (cmd.num) begin
         drem_in = num_sel[DVW-1:0];
         q_in = '0;
      end
      if (cmd.div_step) begin
         drem_in = (div_t >= a_div) ? div_t - a_div : div_t;
         q_in = {q_ff[QW-2:0], div_t >= a_div};
      end
      if (cmd.fin) begin
         prev_x_in = cur_x_ff;
         prev_y_in = cur_y_ff;
         have_prev_in = 1'b1;
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_x_in = (goal_near || !hit_ff) ? goal_x_ff : best_x_ff;
         out_y_in = (goal_near || !hit_ff) ? goal_y_ff : best_y_ff;
         out_found_in = goal_near || hit_ff;
         have_prev_in = 1'b0;
         hit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         car_x_ff <= '0;  car_y_ff <= '0;
         goal_x_ff <= '0; goal_y_ff <= '0;
         gdx_ff <= '0;    gdy_ff <= '0;
         prev_x_ff <= '0; prev_y_ff <= '0;
         best_x_ff <= '0; best_y_ff <= '0;
         have_prev_ff <= 1'b0;
         hit_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         psel_ff <= MS_NONE;
      end else begin
         radius_ff <= radius_in;
         car_x_ff <= car_x_in;   car_y_ff <= car_y_in;
         goal_x_ff <= goal_x_in; goal_y_ff <= goal_y_in;
         gdx_ff <= gdx_in;       gdy_ff <= gdy_in;
         prev_x_ff <= prev_x_in; prev_y_ff <= prev_y_in;
         best_x_ff <= best_x_in; best_y_ff <= best_y_in;
         have_prev_ff <= have_prev_in;
         hit_ff <= hit_in;
         out_valid_ff <= out_valid_in;
         psel_ff <= psel_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in; cur_y_ff <= cur_y_in; last_ff <= last_in;
      dx_ff <= dx_in; dy_ff <= dy_in; fx_ff <= fx_in; fy_ff <= fy_in;
      prod_ff <= prod_in;
      a_ff <= a_in; h_ff <= h_in; cr_ff <= cr_in; g2_ff <= g2_in; r2_ff <= r2_in;
      ma_ff <= ma_in; mb_ff <= mb_in; b1_ff <= b1_in; b2_ff <= b2_in;
      acc1_ff <= acc1_in; acc2_ff <= acc2_in;
      dq_ff <= dq_in; rem_ff <= rem_in; root_ff <= root_in;
      drem_ff <= drem_in; q_ff <= q_in;
      out_x_ff <= out_x_in; out_y_ff <= out_y_in; out_found_ff <= out_found_in;
   end

   assign req.ready = cmd.ready;
   assign rsp.valid = out_valid_ff;
   assign rsp.target_x = out_x_ff;
   assign rsp.target_y = out_y_ff;
   assign rsp.found = out_found_ff;

   assign status.req_valid = req.valid;
   assign status.is_start  = (req.command == CMD_START);
   assign status.is_last   = last_ff;
   assign status.have_prev = have_prev_ff;
   assign status.zero_len  = (dx_ff == '0) && (dy_ff == '0);
   assign status.disc_neg  = acc2_ff < acc1_ff;
   assign status.no_root   = !in1 && !in2;
   assign status.out_busy  = out_valid_ff && !rsp.ready;
endmodule
`default_nettype wire

FILE: rtl/ppl_controller.sv
// Controller state machine that sequences one transaction through the datapath.
`default_nettype none
module ppl_controller (
   input  logic                clock,
   input  logic                reset,
   input  ppl_pkg::status_type status,
   output ppl_pkg::cmd_type    cmd
);
   import ppl_pkg::*;
   `include "pure_pursuit_lookahead_point_assert.svh"

   state_type       state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff + CNTW'(1);
      cmd = '0;
      cmd.mul_sel = MS_NONE;
      case (state_ff)
         ST_IDLE: begin
            cmd.ready = 1'b1;
            cnt_in = '0;
            if (status.req_valid) begin
               cmd.load = 1'b1;
               if (!status.is_start) begin
                  state_in = status.have_prev ? ST_DIFF : ST_FIN;
               end
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            cnt_in = '0;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            if (cnt_ff == '0 && status.zero_len) begin
               state_in = ST_FIN;
            end else begin
               case (cnt_ff)
                  CNTW'(0): cmd.mul_sel = MS_DXDX;
                  CNTW'(1): cmd.mul_sel = MS_DYDY;
                  CNTW'(2): cmd.mul_sel = MS_FXDX;
                  CNTW'(3): cmd.mul_sel = MS_FYDY;
                  CNTW'(4): cmd.mul_sel = MS_DXFY;
                  CNTW'(5): cmd.mul_sel = MS_DYFX;
                  CNTW'(6): cmd.mul_sel = MS_RR;
                  default: begin
                     state_in = ST_MUL;
                     cnt_in = '0;
                  end
               endcase
            end
         end
         ST_MUL: begin
            if (cnt_ff == '0) begin
               cmd.ser_load = 1'b1;
            end else begin
               cmd.ser_step = 1'b1;
               if (cnt_ff == CNTW'(MW)) begin
                  state_in = ST_DISC;
               end
            end
         end
         ST_DISC: begin
            cnt_in = '0;
            if (status.disc_neg) begin
               state_in = ST_FIN;
            end else begin
               cmd.disc = 1'b1;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == CNTW'(SQ_ITER - 1)) begin
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            cnt_in = '0;
            if (status.no_root) begin
               state_in = ST_FIN;
            end else begin
               cmd.num = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_first = (cnt_ff == '0);
            if (cnt_ff == CNTW'(DIV_ITER - 1)) begin
               state_in = ST_LERP;
               cnt_in = '0;
            end
         end
         ST_LERP: begin
            case (cnt_ff)
               CNTW'(0): cmd.mul_sel = MS_TX;
               CNTW'(1): cmd.mul_sel = MS_TY;
               default: state_in = ST_FIN;
            endcase
         end
         ST_FIN: begin
            cmd.fin = 1'b1;
            cnt_in = '0;
            state_in = status.is_last ? ST_GOAL : ST_IDLE;
         end
         ST_GOAL: begin
            case (cnt_ff)
               CNTW'(0): cmd.mul_sel = MS_RR;
               CNTW'(1): cmd.mul_sel = MS_GXGX;
               CNTW'(2): cmd.mul_sel = MS_GYGY;
               default: state_in = ST_EMIT;
            endcase
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `PPL_ASSERT(a_div_count, (state_ff == ST_DIV) |-> (cnt_ff < CNTW'(DIV_ITER)))
   `PPL_ASSERT(a_seg_has_prev, (state_ff == ST_DIFF) |-> status.have_prev)
   `PPL_ASSERT(a_emit_done, (state_ff == ST_EMIT && !status.out_busy) |=> (state_ff == ST_IDLE))
   `PPL_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE))
endmodule
`default_nettype wire

FILE: tb/sv/tb_pure_pursuit_lookahead_point.sv
// Self-checking testbench of the pure pursuit lookahead point block.
`default_nettype none
module tb_pure_pursuit_lookahead_point;
   timeunit 1ns;
   timeprecision 1ps;
   import ppl_pkg::*;

   // Expected target of one closed query.
   typedef struct {
      logic signed [CW-1:0] tx;
      logic signed [CW-1:0] ty;
      logic                 fnd;
   } target_type;

   // Lookahead predictor: its own copy of the query state and the radius.
   class target_scoreboard;
      logic [RW-1:0]        radius;
      logic signed [63:0]   car_px, car_py, goal_px, goal_py;
      logic signed [63:0]   prv_x, prv_y, hit_x, hit_y;
      bit                   has_prev, has_hit;
      target_type           pending[$];
      int                   errors;
      int                   checked;

      function new();
         radius = RADIUS_RESET;
         car_px = 0; car_py = 0; goal_px = 0; goal_py = 0;
         prv_x = 0; prv_y = 0; hit_x = 0; hit_y = 0;
         has_prev = 0; has_hit = 0;
         errors = 0; checked = 0;
      endfunction

      // Interpolate one axis and round half away from zero, then saturate.
      function logic signed [63:0] lerp(logic signed [63:0] p1, logic signed [63:0] d,
                                        logic [63:0] tq);
         logic [127:0]       off;
         logic signed [63:0] v;
         logic [63:0]        mag;
         mag = (d < 0) ? -d : d;
         off = ({64'd0, mag} * {64'd0, tq} + (128'd1 << (T_BITS - 1))) >> T_BITS;
         v = (d < 0) ? p1 - $signed(off[63:0]) : p1 + $signed(off[63:0]);
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         return v;
      endfunction

      // Intersect one segment with the lookahead circle.
      function void segment(logic signed [63:0] x1, logic signed [63:0] y1,
                            logic signed [63:0] x2, logic signed [63:0] y2);
         logic signed [191:0] dx, dy, fx, fy, a, h, cr, disc, s, n1, n2, num, rr;
         logic [191:0]        lo, hi, mid, quo;
         dx = x2 - x1; dy = y2 - y1;
         fx = x1 - car_px; fy = y1 - car_py;
         if (dx == 0 && dy == 0) return;
         a = dx * dx + dy * dy;
         h = fx * dx + fy * dy;
         cr = dx * fy - dy * fx;
         rr = {167'd0, radius};
         disc = a * rr * rr - cr * cr;
         if (disc < 0) return;
         // Integer square root by bisection.
         lo = 0; hi = 192'd1 << 60;
         while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= disc) lo = mid; else hi = mid;
         end
         s = lo;
         n1 = s - h;
         n2 = -h - s;
         if (n1 >= 0 && n1 <= a) num = n1;
         else if (n2 >= 0 && n2 <= a) num = n2;
         else return;
         quo = (num <<< T_BITS) / a;
         hit_x = lerp(x1, dx, quo[63:0]);
         hit_y = lerp(y1, dy, quo[63:0]);
         has_hit = 1;
      endfunction

      // Note an accepted request transaction and queue its target, if any.
      function void note_request(logic cmd, logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                                 logic signed [CW-1:0] gx, logic signed [CW-1:0] gy,
                                 logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                 logic lst);
         target_type         t;
         logic signed [63:0] mx, my;
         bit                 goal_near;
         if (cmd == CMD_START) begin
            car_px = cx; car_py = cy; goal_px = gx; goal_py = gy;
            has_prev = 0; has_hit = 0; hit_x = 0; hit_y = 0;
            return;
         end
         if (has_prev) segment(prv_x, prv_y, px, py);
         prv_x = px; prv_y = py; has_prev = 1;
         if (!lst) return;
         mx = goal_px - car_px; if (mx < 0) mx = -mx;
         my = goal_py - car_py; if (my < 0) my = -my;
         goal_near = (mx < (64'sd1 << GOAL_LIM)) && (my < (64'sd1 << GOAL_LIM)) &&
                     (mx * mx + my * my < $signed({39'd0, radius}) * $signed({39'd0, radius}));
         if (goal_near) begin
            t.tx = goal_px[CW-1:0]; t.ty = goal_py[CW-1:0]; t.fnd = 1;
         end else if (has_hit) begin
            t.tx = hit_x[CW-1:0]; t.ty = hit_y[CW-1:0]; t.fnd = 1;
         end else begin
            t.tx = goal_px[CW-1:0]; t.ty = goal_py[CW-1:0]; t.fnd = 0;
         end
         pending = {pending, t};
         has_prev = 0; has_hit = 0;
      endfunction

      // Compare an accepted response transaction with the oldest expectation.
      function void check_response(logic signed [CW-1:0] tx, logic signed [CW-1:0] ty,
                                   logic fnd);
         target_type t;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected target %0d %0d %0d", tx, ty, fnd);
            return;
         end
         t = pending.pop_front();
         if (t.tx !== tx || t.ty !== ty || t.fnd !== fnd) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: target expected %0d %0d %0d, got %0d %0d %0d",
                        t.tx, t.ty, t.fnd, tx, ty, fnd);
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          csr_wr_en;
   logic [RW-1:0] csr_wr_data;
   int            send_idle;      // percent of cycles the sender idles
   int            recv_stall;     // percent of cycles the receiver stalls
   bit            hold_off;       // long receiver hold-off in progress
   int            sent;

   ppl_req_if req ();
   ppl_rsp_if rsp ();

   pure_pursuit_lookahead_point dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req.sink),
      .rsp         (rsp.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   target_scoreboard sb = new();

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // The run limit allows for every closed segment and for the stalls.
   initial begin
      #(40_000_000);
      $display("Some tests failed");
      $finish;
   end

   // Receiver: stalls at random, or holds off completely during the pressure phase.
   initial begin
      rsp.ready = 0;
      forever begin
         @(posedge clock);
         rsp.ready <= !hold_off && ($urandom_range(99) >= recv_stall);
      end
   end

   // Every accepted response transaction is checked at the edge where it is taken.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_response(rsp.target_x, rsp.target_y, rsp.found);
   end

   // Drive one request transaction and wait until the block takes it.
   // Valid stays high after acceptance; idle cycles and drain() take it low.
   task automatic send_item(logic cmd, logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                            logic signed [CW-1:0] gx, logic signed [CW-1:0] gy,
                            logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                            logic lst);
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1; req.command <= cmd; req.car_x <= cx; req.car_y <= cy;
      req.goal_x <= gx; req.goal_y <= gy; req.point_x <= px; req.point_y <= py;
      req.last <= lst;
      do @(posedge clock); while (!req.ready);
      sb.note_request(cmd, cx, cy, gx, gy, px, py, lst);
      sent++;
   endtask

   task automatic start_query(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                              logic signed [CW-1:0] gx, logic signed [CW-1:0] gy);
      send_item(CMD_START, cx, cy, gx, gy, $urandom, $urandom, $urandom_range(1));
   endtask

   task automatic send_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py, logic lst);
      send_item(CMD_POINT, $urandom, $urandom, $urandom, $urandom, px, py, lst);
   endtask

   // Wait until all targets have arrived, then let the block settle.
   task automatic drain();
      req.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_radius(logic [RW-1:0] r);
      drain();
      csr_wr_en <= 1; csr_wr_data <= r;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.radius = r;
   endtask

   // Random coordinate: mostly near the vehicle so circles get hit, sometimes full range.
   function automatic logic signed [CW-1:0] near(logic signed [CW-1:0] c, int span);
      if ($urandom_range(15) == 0) return $urandom;
      return c + $signed($urandom_range(2 * span) - span);
   endfunction

   // One random well-formed query, or occasionally a broken one.
   task automatic random_query(int span);
      logic signed [CW-1:0] cx, cy, px, py;
      int                   n;
      cx = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(2_000_000) - 1_000_000);
      cy = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(2_000_000) - 1_000_000);
      if ($urandom_range(9) != 0)
         start_query(cx, cy, near(cx, 4 * span), near(cy, 4 * span));
      else begin
         cx = sb.car_px[CW-1:0]; cy = sb.car_py[CW-1:0];
      end
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(9) == 0) begin
            px = sb.prv_x[CW-1:0]; py = sb.prv_y[CW-1:0];   // zero-length segment
         end else begin
            px = near(cx, 2 * span); py = near(cy, 2 * span);
         end
         send_point(px, py, (i == n - 1) && ($urandom_range(19) != 0));
      end
   endtask

   // Pressure phase: the receiver holds off for a long stretch while queries keep coming.
   initial begin
      hold_off = 0;
      wait (sent >= 1200);
      hold_off = 1;
      for (int k = 0; k < 3000; k++) @(posedge clock);
      hold_off = 0;
   end

   initial begin
      logic [RW-1:0] radii[6];
      radii = '{25'd98304, 25'd0, 25'd16777216, 25'd1, 25'd1048576, 25'd33554431};
      sent = 0;
      send_idle = 0; recv_stall = 0;
      reset = 1; csr_wr_en = 0; csr_wr_data = '0;
      req.valid = 0; req.command = CMD_START; req.car_x = 0; req.car_y = 0;
      req.goal_x = 0; req.goal_y = 0; req.point_x = 0; req.point_y = 0; req.last = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part with the reset radius of 1.5 m.
      // Points before any start use a vehicle and goal at the origin.
      send_point(-32'sd200000, 0, 0);
      send_point(32'sd200000, 0, 1);
      // Goal within the radius wins over any hit.
      start_query(0, 0, 32'sd65536, 0);
      send_point(-32'sd200000, 10, 0);
      send_point(32'sd200000, 10, 1);
      // Path missing the circle, so the goal comes back with found clear.
      start_query(32'sd1000, -32'sd1000, 32'h7FFFFFFF, 32'sh80000000);
      send_point(32'sh80000000, 32'sh80000000, 0);
      send_point(32'h7FFFFFFF, 32'sh80000000, 0);
      send_point(32'h7FFFFFFF, 32'sh80000000, 0);   // zero-length segment
      send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 1);
      // Single point query and a follow-on query without a start.
      send_point(5, 5, 1);
      send_point(32'sh80000000, 32'h7FFFFFFF, 0);
      send_point(32'h7FFFFFFF, 32'sh80000000, 1);
      // Two hits where the later replaces the earlier.
      start_query(0, 0, 32'sd10000000, 32'sd10000000);
      send_point(-32'sd300000, 0, 0);
      send_point(0, 32'sd1, 0);
      send_point(0, 32'sd300000, 1);
      // Zero radius: only a path exactly through the vehicle hits.
      write_radius(25'd0);
      start_query(32'sd7, 32'sd7, 32'sd7, 32'sd7);
      send_point(-32'sd100, 32'sd7, 0);
      send_point(32'sd100, 32'sd7, 1);
      write_radius(25'd16777216);
      start_query(32'sh80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'sh80000000);
      send_point(32'sh80000000, 32'sh80000000, 0);
      send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 1);

      // Random part in idling phases, stepping through the radius settings.
      for (int ph = 0; ph < 6; ph++) begin
         write_radius(radii[ph] == 25'd33554431 ? ($urandom & 25'h1FFFFFF) : radii[ph]);
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 63; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 63; end
            default: begin send_idle = 35; recv_stall = 35; end
         endcase
         while (sent < 26 + (ph + 1) * 315)
            random_query((sb.radius == 0) ? 1000 : int'(sb.radius) + 1);
      end

      drain();
      $display("Sent %0d request transactions over six radius settings and checked %0d targets.",
               sent, sb.checked);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Mismatches: %0d", sb.errors);
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/ppl_pkg.sv
rtl/ppl_if.sv
rtl/ppl_datapath.sv
rtl/ppl_controller.sv
rtl/pure_pursuit_lookahead_point.sv
tb/sv/tb_pure_pursuit_lookahead_point.sv
